// File: hw/rtl/rhce_pkg.sv
// ----------------------------------------------------------------------------
// rhce_pkg
// shared types and constants of the rgb histogram / cdf engine
// ----------------------------------------------------------------------------
package rhce_pkg;

  localparam int unsigned CountWidth = 24;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned BinBits    = 8;
  localparam int unsigned NumBins    = 256;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] op;
    logic       first_pixel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] channel_sel;
    logic [7:0] bin_index;
  } req_t;

  typedef struct packed {
    logic [CountWidth-1:0] bin_count;
    logic [CountWidth-1:0] cumulative_count;
    logic [FracBits:0]     bin_fraction;
    logic [FracBits:0]     cumulative_fraction;
    logic                  count_is_zero;
  } rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e                 op;
    logic                first_pixel;
    logic [BinBits-1:0]  red;
    logic [BinBits-1:0]  green;
    logic [BinBits-1:0]  blue;
    logic [BinBits-1:0]  mean;
    logic [1:0]          channel_sel;
    logic [BinBits-1:0]  bin_index;
  } cmd_t;

endpackage

// File: hw/rtl/rhce_front.sv
// ----------------------------------------------------------------------------
// rhce_front
// accepts requests, computes the pixel mean, queues commands for the back end
// ----------------------------------------------------------------------------
module rhce_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  rhce_pkg::req_t  req_i,
  output logic            busy,
  output logic            cmd_valid_o,
  output rhce_pkg::cmd_t  cmd_o,
  input  logic            cmd_pop_i
);

  localparam int unsigned PW = rhce_pkg::QueuePtrW;

  rhce_pkg::cmd_t             mem_q [rhce_pkg::QueueDepth];
  logic [PW-1:0]              wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]                cnt_q, cnt_d;
  rhce_pkg::cmd_t             cmd_in;
  logic [9:0]                 sum;
  logic [7:0]                 mean;
  logic                       push, pop;

  // floor(s/3) for s < 768 via reciprocal 683/2048 with correction
  logic [19:0] prod;
  logic [9:0]  qest, rem;
  always_comb begin
    sum  = {2'b0, req_i.red} + {2'b0, req_i.green} + {2'b0, req_i.blue};
    prod = sum * 10'd683;
    qest = {1'b0, prod[19:11]};
    rem  = sum - 10'(qest * 10'd3);
    if (rem >= 10'd3) begin
      mean = 8'(qest + 10'd1);
    end else begin
      mean = qest[7:0];
    end
  end

  always_comb begin
    cmd_in.op          = rhce_pkg::op_e'(req_i.op);
    cmd_in.first_pixel = req_i.first_pixel;
    cmd_in.red         = req_i.red;
    cmd_in.green       = req_i.green;
    cmd_in.blue        = req_i.blue;
    cmd_in.mean        = mean;
    cmd_in.channel_sel = req_i.channel_sel;
    cmd_in.bin_index   = req_i.bin_index;
  end

  assign busy        = (cnt_q == (PW+1)'(rhce_pkg::QueueDepth));
  assign push        = start && !busy && (req_i.op != rhce_pkg::OP_NONE);
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

endmodule

// File: hw/rtl/rhce_divider.sv
// ----------------------------------------------------------------------------
// rhce_divider
// radix-2 restoring divider for the q16 shares, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rhce_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                go_i,
  input  logic [rhce_pkg::CountWidth-1:0]     num_i,
  input  logic [rhce_pkg::CountWidth-1:0]     den_i,
  output logic                                done_o,
  output logic [rhce_pkg::FracBits:0]         frac_o
);

  localparam int unsigned NW = rhce_pkg::CountWidth + rhce_pkg::FracBits;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]                   quo_q, quo_d;
  logic [rhce_pkg::CountWidth:0]   rem_q, rem_d;
  logic [rhce_pkg::CountWidth-1:0] den_q;
  logic [CW-1:0]                   cnt_q, cnt_d;
  logic                            run_q, run_d, done_q, done_d;
  logic [rhce_pkg::CountWidth:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q[rhce_pkg::CountWidth-1:0], quo_q[NW-1]};
    if (go_i) begin
      quo_d = {num_i, {rhce_pkg::FracBits{1'b0}}};
      rem_d = '0;
      cnt_d = CW'(NW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (go_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  always_comb begin
    if (den_q == '0) begin
      frac_o = '0;
    end else if (quo_q > NW'(1 << rhce_pkg::FracBits)) begin
      frac_o = {1'b1, {rhce_pkg::FracBits{1'b0}}};
    end else begin
      frac_o = quo_q[rhce_pkg::FracBits:0];
    end
  end

endmodule

// File: hw/rtl/rhce_back.sv
// ----------------------------------------------------------------------------
// rhce_back
// bin memories, clear sweep, pixel counter, running sum and read sequencer
// ----------------------------------------------------------------------------
module rhce_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  rhce_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  output logic            done,
  output rhce_pkg::rsp_t  rsp_o
);

  localparam int unsigned CW = rhce_pkg::CountWidth;
  localparam int unsigned BW = rhce_pkg::BinBits;
  localparam logic [CW-1:0] CntMax = '1;

  typedef enum logic [8:0] {
    ST_INIT  = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_PXRD  = 9'b000000100,
    ST_PXWR  = 9'b000001000,
    ST_CLEAR = 9'b000010000,
    ST_RDRD  = 9'b000100000,
    ST_DIV1  = 9'b001000000,
    ST_DIV2  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] bins_q [4][rhce_pkg::NumBins];
  logic [CW-1:0] rd_data_q [4];
  logic [BW-1:0] addr [4];
  logic [CW-1:0] wdata [4];
  logic          we;
  logic [BW:0]   sweep_q, sweep_d;
  logic [CW-1:0] pix_q, pix_d, sum_q, sum_d, val_q, val_d;
  logic [CW:0]   acc;
  rhce_pkg::cmd_t cmd_q;
  logic          load;
  logic          dgo;
  logic [CW-1:0] dnum;
  logic          ddone;
  logic [rhce_pkg::FracBits:0] dfrac, bfrac_q, bfrac_d;
  logic [CW-1:0] rdsel;

  rhce_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (dgo),
    .num_i  (dnum),
    .den_i  (pix_q),
    .done_o (ddone),
    .frac_o (dfrac)
  );

  assign load      = (state_q == ST_IDLE) && cmd_valid_i;
  assign cmd_pop_o = load;

  always_comb begin
    unique case (cmd_q.channel_sel)
      2'd0:    rdsel = rd_data_q[0];
      2'd1:    rdsel = rd_data_q[1];
      2'd2:    rdsel = rd_data_q[2];
      default: rdsel = rd_data_q[3];
    endcase
  end

  always_comb begin
    addr[0] = cmd_q.red;
    addr[1] = cmd_q.green;
    addr[2] = cmd_q.blue;
    addr[3] = cmd_q.mean;
    we      = 1'b0;
    for (int i = 0; i < 4; i++) begin
      wdata[i] = (rd_data_q[i] == CntMax) ? CntMax : rd_data_q[i] + 1'b1;
    end
    if (state_q == ST_INIT || state_q == ST_CLEAR) begin
      for (int i = 0; i < 4; i++) begin
        addr[i]  = sweep_q[BW-1:0];
        wdata[i] = '0;
      end
      we = 1'b1;
    end else if (state_q == ST_RDRD) begin
      for (int i = 0; i < 4; i++) begin
        addr[i] = cmd_q.bin_index;
      end
    end else if (state_q == ST_PXWR) begin
      we = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    pix_d   = pix_q;
    sum_d   = sum_q;
    val_d   = val_q;
    bfrac_d = bfrac_q;
    dgo     = 1'b0;
    dnum    = val_q;
    acc     = {1'b0, sum_q} + {1'b0, rdsel};
    done    = 1'b0;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == (BW+1)'(rhce_pkg::NumBins - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            rhce_pkg::OP_PIXEL: state_d = ST_PXRD;
            rhce_pkg::OP_CLEAR: begin
              state_d = ST_CLEAR;
              sweep_d = '0;
            end
            rhce_pkg::OP_READ:  state_d = ST_RDRD;
            default:            state_d = ST_IDLE;
          endcase
        end
      end
      ST_PXRD: state_d = ST_PXWR;
      ST_PXWR: begin
        if (cmd_q.first_pixel) begin
          pix_d = CW'(1);
        end else if (pix_q != CntMax) begin
          pix_d = pix_q + 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_RDRD: state_d = ST_DIV1;
      ST_DIV1: begin
        // read data is valid now: latch bin, update running sum, start share
        val_d = rdsel;
        if (cmd_q.bin_index == '0) begin
          sum_d = rdsel;
        end else begin
          sum_d = acc[CW] ? CntMax : acc[CW-1:0];
        end
        dgo     = 1'b1;
        dnum    = rdsel;
        state_d = ST_DIV2;
      end
      ST_DIV2: begin
        if (ddone) begin
          bfrac_d = dfrac;
          dgo     = 1'b1;
          dnum    = sum_q;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (ddone) begin
          done    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.bin_count           = val_q;
    rsp_o.cumulative_count    = sum_q;
    rsp_o.bin_fraction        = bfrac_q;
    rsp_o.cumulative_fraction = dfrac;
    rsp_o.count_is_zero       = (pix_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      sweep_q <= '0;
      pix_q   <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      pix_q   <= pix_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    bfrac_q <= bfrac_d;
    if (load) begin
      cmd_q <= cmd_i;
    end
  end

  // four bin memories, one port each
  always_ff @(posedge clk_i) begin
    for (int g = 0; g < 4; g++) begin
      if (we) begin
        bins_q[g][addr[g]] <= wdata[g];
      end
      rd_data_q[g] <= bins_q[g][addr[g]];
    end
  end

endmodule

// File: hw/rtl/rgb_histogram_cdf_engine.sv
// ----------------------------------------------------------------------------
// rgb_histogram_cdf_engine
// red, green, blue and mean histograms with cumulative distribution readout
// ----------------------------------------------------------------------------
// usage
//   a request is taken on a rising edge with start high and busy low; op picks
//   pixel, clear all bins or read one bin, op 3 is dropped
//   requests land in a four-entry command queue; busy rises only when it fills
//   the back end runs one command at a time out of four 256 x 24 bin memories
//   pixel: read bin, write incremented bin
//   clear: one address of all four memories per cycle
//   read: the bit-serial divider forms the two q16 shares one after the
//     other, 40 steps each
//   a read result shows on rsp_o for one cycle with done high; the receiver
//   cannot stall, so done is a plain strobe
//   reading bins 0..255 of one channel in order walks out the cdf; bin 0
//   reloads the shared running sum
//   after reset the block sweeps the memories to zero; queued requests wait,
//   and busy follows the queue as ever
// ----------------------------------------------------------------------------
module rgb_histogram_cdf_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  rhce_pkg::req_t req_i,
  output logic           busy,
  output logic           done,
  output rhce_pkg::rsp_t rsp_o
);

  // command queue handshake between front and back
  logic           cmd_valid;
  logic           cmd_pop;
  rhce_pkg::cmd_t cmd;

  rhce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rhce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .done        (done),
    .rsp_o       (rsp_o)
  );

endmodule

// File: sim/rhce_checker.sv
// ----------------------------------------------------------------------------
// rhce_checker
// watches requests and read responses of the histogram engine, predicts each
// response from a private copy of the bins and counters, compares it whole
// ----------------------------------------------------------------------------
module rhce_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  rhce_pkg::req_t   req_i,
  input  logic             done_i,
  input  rhce_pkg::rsp_t   rsp_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  localparam logic [rhce_pkg::CountWidth-1:0] CntMax  = '1;
  localparam logic [rhce_pkg::FracBits:0]     FracOne =
    {1'b1, {rhce_pkg::FracBits{1'b0}}};

  logic [rhce_pkg::CountWidth-1:0] hist_q [4][rhce_pkg::NumBins];
  logic [rhce_pkg::CountWidth-1:0] pixels_q;
  logic [rhce_pkg::CountWidth-1:0] cdf_sum_q;
  rhce_pkg::rsp_t                  expected_rsps [$];
  int unsigned                     fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_rsps.size();

  function automatic logic [rhce_pkg::CountWidth-1:0] bump(
      logic [rhce_pkg::CountWidth-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [rhce_pkg::FracBits:0] q16_share(
      logic [rhce_pkg::CountWidth-1:0] num, logic [rhce_pkg::CountWidth-1:0] den);
    logic [63:0] q;
    if (den == 0) return '0;
    q = ({40'd0, num} << rhce_pkg::FracBits) / den;
    return (q > FracOne) ? FracOne : q[rhce_pkg::FracBits:0];
  endfunction

  task automatic apply_request(rhce_pkg::req_t r);
    logic [9:0]                      sum3;
    logic [7:0]                      mean;
    logic [rhce_pkg::CountWidth-1:0] v;
    logic [rhce_pkg::CountWidth:0]   acc;
    rhce_pkg::rsp_t                  e;
    case (rhce_pkg::op_e'(r.op))
      rhce_pkg::OP_PIXEL: begin
        sum3 = r.red + r.green + r.blue;
        mean = 8'(sum3 / 3);
        hist_q[0][r.red]   = bump(hist_q[0][r.red]);
        hist_q[1][r.green] = bump(hist_q[1][r.green]);
        hist_q[2][r.blue]  = bump(hist_q[2][r.blue]);
        hist_q[3][mean]    = bump(hist_q[3][mean]);
        pixels_q = r.first_pixel ? rhce_pkg::CountWidth'(1) : bump(pixels_q);
      end
      rhce_pkg::OP_CLEAR: begin
        foreach (hist_q[c, b]) hist_q[c][b] = '0;
      end
      rhce_pkg::OP_READ: begin
        v = hist_q[r.channel_sel][r.bin_index];
        if (r.bin_index == 0) cdf_sum_q = v;
        else begin
          acc = cdf_sum_q + v;
          cdf_sum_q = acc[rhce_pkg::CountWidth] ? CntMax : acc[rhce_pkg::CountWidth-1:0];
        end
        e.bin_count           = v;
        e.cumulative_count    = cdf_sum_q;
        e.bin_fraction        = q16_share(v, pixels_q);
        e.cumulative_fraction = q16_share(cdf_sum_q, pixels_q);
        e.count_is_zero       = (pixels_q == 0);
        expected_rsps.push_back(e);
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, rhce_pkg::rsp_t e, rhce_pkg::rsp_t a);
    fails++;
    if (fails <= 10) begin
      $display("%0t %s exp cnt=%0d cum=%0d bf=%0d cf=%0d z=%0d",
               $time, what, e.bin_count, e.cumulative_count, e.bin_fraction,
               e.cumulative_fraction, e.count_is_zero);
      $display("    act cnt=%0d cum=%0d bf=%0d cf=%0d z=%0d",
               a.bin_count, a.cumulative_count, a.bin_fraction,
               a.cumulative_fraction, a.count_is_zero);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rhce_pkg::rsp_t e;
    if (!rst_ni) begin
      foreach (hist_q[c, b]) hist_q[c][b] = '0;
      pixels_q  = '0;
      cdf_sum_q = '0;
      expected_rsps.delete();
      fails = 0;
    end else begin
      // responses first: a response never stems from a request taken this edge
      if (done_i) begin
        if (expected_rsps.size() == 0) report("unexpected response", '0, rsp_i);
        else begin
          e = expected_rsps.pop_front();
          if (rsp_i !== e) report("response", e, rsp_i);
        end
      end
      if (start_i && !busy_i) apply_request(req_i);
    end
  end

endmodule

// File: sim/tb_rgb_histogram_cdf_engine.sv
// ----------------------------------------------------------------------------
// tb_rgb_histogram_cdf_engine
// drives directed and random pixel / clear / read requests into the engine,
// a checker beside the block predicts and compares every read response
// ----------------------------------------------------------------------------
module tb_rgb_histogram_cdf_engine;

  localparam int unsigned CycleLimit = 2_000_000;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  rhce_pkg::req_t req;
  logic           busy;
  logic           done;
  rhce_pkg::rsp_t rsp;
  int unsigned    fail_count;
  int unsigned    pending;
  int unsigned    cycles;
  logic           quiet;   // no idle gaps in the final stretch

  rgb_histogram_cdf_engine uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req),
    .busy   (busy),
    .done   (done),
    .rsp_o  (rsp)
  );

  rhce_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .done_i       (done),
    .rsp_i        (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on the total cycle count
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("rgb_histogram_cdf_engine: mismatch");
      $finish;
    end
  end

  // hand one request over and hold it until the engine takes it
  task automatic send(rhce_pkg::req_t r);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic rhce_pkg::req_t make(rhce_pkg::op_e op, logic fp, logic [7:0] r,
                                          logic [7:0] g, logic [7:0] b, logic [1:0] ch,
                                          logic [7:0] idx);
    rhce_pkg::req_t q;
    q.op = op; q.first_pixel = fp; q.red = r; q.green = g; q.blue = b;
    q.channel_sel = ch; q.bin_index = idx;
    return q;
  endfunction

  // fully random content of every field but op
  function automatic rhce_pkg::req_t noise(rhce_pkg::op_e op);
    rhce_pkg::req_t q;
    logic [63:0]    raw;
    raw = {$urandom, $urandom};
    q = raw[$bits(rhce_pkg::req_t)-1:0];
    q.op = op;
    return q;
  endfunction

  initial begin
    int unsigned n;
    int unsigned lim;
    int unsigned ch;
    quiet  = 1'b0;
    start  = 1'b0;
    req    = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reads with zero pixel count, extremes, mean corners, op 3, clear
    send(make(rhce_pkg::OP_READ, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 8'd0));
    send(make(rhce_pkg::OP_READ, 1'b0, 8'h00, 8'h00, 8'h00, 2'd3, 8'd255));
    send(make(rhce_pkg::OP_PIXEL, 1'b1, 8'hff, 8'hff, 8'hff, 2'd3, 8'hff));
    send(make(rhce_pkg::OP_PIXEL, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 8'h00));
    send(make(rhce_pkg::OP_PIXEL, 1'b0, 8'hff, 8'h00, 8'h01, 2'd0, 8'h00));
    send(make(rhce_pkg::OP_PIXEL, 1'b0, 8'h01, 8'h01, 8'h00, 2'd0, 8'h00));
    send(make(rhce_pkg::OP_NONE, 1'b1, 8'h12, 8'h34, 8'h56, 2'd1, 8'd7));
    send(make(rhce_pkg::OP_READ, 1'b1, 8'hff, 8'hff, 8'hff, 2'd0, 8'd0));
    send(make(rhce_pkg::OP_READ, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 8'd255));
    send(make(rhce_pkg::OP_READ, 1'b0, 8'h00, 8'h00, 8'h00, 2'd1, 8'd0));
    send(make(rhce_pkg::OP_READ, 1'b0, 8'h00, 8'h00, 8'h00, 2'd2, 8'd255));
    send(make(rhce_pkg::OP_READ, 1'b0, 8'h00, 8'h00, 8'h00, 2'd3, 8'd85));
    send(make(rhce_pkg::OP_READ, 1'b0, 8'h00, 8'h00, 8'h00, 2'd3, 8'd255));
    // first pixel restarts the count but keeps the bins: shares above 1.0 saturate
    send(make(rhce_pkg::OP_PIXEL, 1'b1, 8'h00, 8'h00, 8'h00, 2'd0, 8'h00));
    send(make(rhce_pkg::OP_READ, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 8'd0));
    send(make(rhce_pkg::OP_READ, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 8'd255));
    send(make(rhce_pkg::OP_CLEAR, 1'b1, 8'hff, 8'hff, 8'hff, 2'd3, 8'hff));
    send(make(rhce_pkg::OP_READ, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 8'd0));

    // random: images of random pixels, then cdf walks over the small bin range
    n = 0;
    while (n < 850) begin
      if (n > 760) quiet = 1'b1;
      lim = $urandom_range(1, 60);
      for (int i = 0; i < lim; i++) begin
        rhce_pkg::req_t p;
        p = noise(rhce_pkg::OP_PIXEL);
        p.first_pixel = (i == 0) ? 1'($urandom_range(0, 1))
                                 : ($urandom_range(0, 40) == 0);
        if ($urandom_range(0, 1)) begin
          p.red = 8'($urandom_range(0, 7)); p.green = 8'($urandom_range(0, 7));
          p.blue = 8'($urandom_range(0, 7));
        end
        send(p);
        n++;
      end
      ch = $urandom_range(0, 3);
      lim = $urandom_range(0, 10);
      for (int b = 0; b <= lim; b++) begin
        rhce_pkg::req_t q;
        q = noise(rhce_pkg::OP_READ);
        q.channel_sel = 2'(ch);
        q.bin_index   = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'(b);
        send(q);
        n++;
      end
      case ($urandom_range(0, 9))
        0: begin send(noise(rhce_pkg::OP_CLEAR)); n++; end
        1: send(noise(rhce_pkg::OP_NONE));
        default: ;
      endcase
    end
    start <= 1'b0;

    lim = 0;
    while (pending != 0 && lim < 100_000) begin
      @(posedge clk_i);
      lim++;
    end
    repeat (400) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("rgb_histogram_cdf_engine: match");
    end else begin
      $display("rgb_histogram_cdf_engine: mismatch");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/rhce_pkg.sv
hw/rtl/rhce_front.sv
hw/rtl/rhce_divider.sv
hw/rtl/rhce_back.sv
hw/rtl/rgb_histogram_cdf_engine.sv
sim/rhce_checker.sv
sim/tb_rgb_histogram_cdf_engine.sv
